>>> design/byte_budget_frame_cache_unit_macros.svh
// Assertion macros shared by the frame cache RTL.
// They expect the signals clk and arst_n in the scope of the module that uses them.
`ifndef BYTE_BUDGET_FRAME_CACHE_UNIT_MACROS_SVH
`define BYTE_BUDGET_FRAME_CACHE_UNIT_MACROS_SVH

// Checks that the consequence holds in the same cycle as the antecedent.
`define BBFC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequence holds in the cycle after the antecedent.
`define BBFC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/bbfc_pkg.sv
// Shared types and constants of the byte budget frame cache.
// No dependencies; imported by the top level and the testbench.
package bbfc_pkg;

	localparam int CAPACITY = 64;
	localparam int SLOTS    = CAPACITY + 1;
	localparam int AW       = $clog2(SLOTS);
	localparam int CW       = $clog2(SLOTS + 1);
	localparam int OUT_CW   = 7;

	typedef enum logic [2:0] {
		OP_INSERT  = 3'd0,
		OP_FIND    = 3'd1,
		OP_DISCARD = 3'd2,
		OP_CLEAR   = 3'd3,
		OP_SET_GEN = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		OUTCOME_ADDED    = 2'd0,
		OUTCOME_REPLACED = 2'd1,
		OUTCOME_REJECTED = 2'd2
	} outcome_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_WRITE,
		ST_EVCHK,
		ST_EVICT,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		SCAN_MATCH,
		SCAN_DISCARD,
		SCAN_HIGH,
		SCAN_SUMMARY
	} scan_mode_t;

	typedef struct packed {
		logic [31:0] idx;
		logic [31:0] bytes;
		logic [15:0] handle;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> design/bbfc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Stands alone; used for the entry table of the frame cache.
module bbfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/byte_budget_frame_cache_unit.sv
// Top level of the byte budget frame cache: control sequencer and entry valid bits.
// Depends on bbfc_pkg, bbfc_ram and byte_budget_frame_cache_unit_macros.svh.

// The block handles one transaction at a time. Entries live in a RAM of
// CAPACITY+1 rows that is walked one row per cycle. Find and discard take
// two walks; clear, set generation, unknown codes and a rejected insert
// take one, and an accepted insert takes two walks plus a write plus one
// further walk for each entry it evicts. The valid bits are flip-flops
// cleared at reset, so the block accepts work right after reset with no
// clearing pass. A finished result waits in an output register, and the
// next transaction is taken while it does.
`include "byte_budget_frame_cache_unit_macros.svh"

module byte_budget_frame_cache_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [39:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  operation,
	input  logic [31:0] frame_index,
	input  logic [31:0] frame_bytes,
	input  logic        frame_valid,
	input  logic [15:0] frame_handle,
	input  logic [31:0] generation,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        hit,
	output logic [15:0] found_handle,
	output logic [31:0] found_bytes,
	output logic [1:0]  insert_outcome,
	output logic [6:0]  evicted_count,
	output logic [6:0]  discarded_count,
	output logic        is_empty,
	output logic [31:0] first_index,
	output logic [31:0] last_index,
	output logic [47:0] used_bytes
);

	import bbfc_pkg::*;

	state_t state_q, state_d;
	scan_mode_t mode_q, mode_d;
	logic start_scan, ram_we, load_result, scan_done;

	logic [39:0] budget_q;
	logic [31:0] gen_q;
	logic [47:0] used_q;
	logic [CW-1:0] count_q;
	logic [SLOTS-1:0] valid_q;

	logic [2:0]  op_q;
	logic [31:0] op_idx_q, op_bytes_q, op_gen_q;
	logic        op_fvalid_q;
	logic [15:0] op_handle_q;

	logic [CW-1:0] rd_addr_q;
	logic [AW-1:0] raddr, waddr;
	logic          act_s1;
	logic [AW-1:0] addr_s1;
	entry_t        rdata, wdata;
	logic          v_s1;

	logic          match_found_q, free_found_q, hi_found_q;
	logic [AW-1:0] match_slot_q, free_slot_q, hi_slot_q;
	logic [31:0]   match_bytes_q, hi_idx_q, hi_bytes_q;

	logic          hit_q, empty_q;
	logic [15:0]   fh_q;
	logic [31:0]   fb_q, first_q, last_q;
	outcome_t      outcome_q;
	logic [CW-1:0] evicted_q, discarded_q;

	logic          out_valid_q;
	logic          r_hit_q, r_empty_q;
	logic [15:0]   r_fh_q;
	logic [31:0]   r_fb_q, r_first_q, r_last_q;
	logic [1:0]    r_outcome_q;
	logic [6:0]    r_evicted_q, r_discarded_q;
	logic [47:0]   r_used_q;

	logic need_evict;

	assign scan_done  = (rd_addr_q == CW'(SLOTS)) && !act_s1;
	assign raddr      = (rd_addr_q == CW'(SLOTS)) ? '0 : rd_addr_q[AW-1:0];
	assign v_s1       = valid_q[addr_s1];
	assign need_evict = (count_q > CW'(1))
		&& ((used_q > {8'd0, budget_q}) || (count_q > CW'(CAPACITY)));
	assign waddr      = match_found_q ? match_slot_q : free_slot_q;
	assign wdata      = '{idx: op_idx_q, bytes: op_bytes_q, handle: op_handle_q};

	bbfc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECODE;
			end
			ST_DECODE: state_d = ST_SCAN;
			ST_SCAN: begin
				if (scan_done) begin
					case (mode_q)
						SCAN_MATCH: state_d = (op_q == OP_FIND) ? ST_SCAN : ST_WRITE;
						SCAN_DISCARD: state_d = ST_SCAN;
						SCAN_HIGH: state_d = ST_EVICT;
						SCAN_SUMMARY: state_d = ST_DONE;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_WRITE: state_d = match_found_q ? ST_SCAN : ST_EVCHK;
			ST_EVICT: state_d = ST_EVCHK;
			ST_EVCHK: state_d = ST_SCAN;
			ST_DONE: begin
				if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall    = (state_q != ST_IDLE);
		ram_we      = (state_q == ST_WRITE);
		load_result = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
		start_scan  = 1'b0;
		mode_d      = SCAN_SUMMARY;
		case (state_q)
			ST_DECODE: begin
				start_scan = 1'b1;
				if ((op_q == OP_INSERT && op_fvalid_q && op_gen_q == gen_q)
					|| op_q == OP_FIND) begin
					mode_d = SCAN_MATCH;
				end else if (op_q == OP_DISCARD) begin
					mode_d = SCAN_DISCARD;
				end
			end
			ST_SCAN: begin
				start_scan = scan_done && (mode_q == SCAN_DISCARD
					|| (mode_q == SCAN_MATCH && op_q == OP_FIND));
			end
			ST_WRITE: start_scan = match_found_q;
			ST_EVCHK: begin
				start_scan = 1'b1;
				if (need_evict) mode_d = SCAN_HIGH;
			end
			default: start_scan = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= SCAN_SUMMARY;
			budget_q    <= 40'd536870912;
			gen_q       <= '0;
			used_q      <= '0;
			count_q     <= '0;
			valid_q     <= '0;
			rd_addr_q   <= '0;
			act_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) budget_q <= cfg_data;
			out_valid_q <= load_result || (out_valid_q && out_stall);

			if (state_q == ST_DECODE) begin
				if (op_q == OP_CLEAR || (op_q == OP_SET_GEN && op_gen_q != gen_q)) begin
					valid_q <= '0;
					used_q  <= '0;
					count_q <= '0;
				end
				if (op_q == OP_SET_GEN) gen_q <= op_gen_q;
			end

			if (state_q == ST_SCAN && act_s1 && v_s1 && mode_q == SCAN_DISCARD
				&& rdata.idx < op_idx_q) begin
				valid_q[addr_s1] <= 1'b0;
				used_q  <= used_q - {16'd0, rdata.bytes};
				count_q <= count_q - CW'(1);
			end

			if (state_q == ST_WRITE) begin
				if (match_found_q) begin
					used_q <= used_q - {16'd0, match_bytes_q} + {16'd0, op_bytes_q};
				end else begin
					used_q <= used_q + {16'd0, op_bytes_q};
					valid_q[free_slot_q] <= 1'b1;
					count_q <= count_q + CW'(1);
				end
			end

			if (state_q == ST_EVICT) begin
				valid_q[hi_slot_q] <= 1'b0;
				used_q  <= used_q - {16'd0, hi_bytes_q};
				count_q <= count_q - CW'(1);
			end

			if (start_scan) begin
				mode_q    <= mode_d;
				rd_addr_q <= '0;
				act_s1    <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				if (rd_addr_q != CW'(SLOTS)) begin
					rd_addr_q <= rd_addr_q + CW'(1);
					act_s1    <= 1'b1;
				end else begin
					act_s1 <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			op_q        <= operation;
			op_idx_q    <= frame_index;
			op_bytes_q  <= frame_bytes;
			op_fvalid_q <= frame_valid;
			op_handle_q <= frame_handle;
			op_gen_q    <= generation;
			hit_q       <= 1'b0;
			fh_q        <= '0;
			fb_q        <= '0;
			outcome_q   <= OUTCOME_ADDED;
			evicted_q   <= '0;
			discarded_q <= '0;
		end

		if (state_q == ST_DECODE) begin
			if (op_q == OP_INSERT && (!op_fvalid_q || op_gen_q != gen_q)) begin
				outcome_q <= OUTCOME_REJECTED;
			end
			if (op_q == OP_CLEAR || (op_q == OP_SET_GEN && op_gen_q != gen_q)) begin
				discarded_q <= count_q;
			end
		end

		if (start_scan) begin
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			hi_found_q    <= 1'b0;
			empty_q       <= 1'b1;
			first_q       <= '0;
			last_q        <= '0;
		end else if (state_q == ST_SCAN && act_s1) begin
			case (mode_q)
				SCAN_MATCH: begin
					if (v_s1 && rdata.idx == op_idx_q && !match_found_q) begin
						match_found_q <= 1'b1;
						match_slot_q  <= addr_s1;
						match_bytes_q <= rdata.bytes;
						if (op_q == OP_FIND) begin
							hit_q <= 1'b1;
							fh_q  <= rdata.handle;
							fb_q  <= rdata.bytes;
						end
					end
					if (!v_s1 && !free_found_q) begin
						free_found_q <= 1'b1;
						free_slot_q  <= addr_s1;
					end
				end
				SCAN_DISCARD: begin
					if (v_s1 && rdata.idx < op_idx_q) discarded_q <= discarded_q + CW'(1);
				end
				SCAN_HIGH: begin
					if (v_s1 && (!hi_found_q || rdata.idx > hi_idx_q)) begin
						hi_found_q <= 1'b1;
						hi_slot_q  <= addr_s1;
						hi_idx_q   <= rdata.idx;
						hi_bytes_q <= rdata.bytes;
					end
				end
				SCAN_SUMMARY: begin
					if (v_s1) begin
						empty_q <= 1'b0;
						if (empty_q || rdata.idx < first_q) first_q <= rdata.idx;
						if (empty_q || rdata.idx > last_q) last_q <= rdata.idx;
					end
				end
				default: empty_q <= empty_q;
			endcase
		end

		if (state_q == ST_SCAN && !start_scan) addr_s1 <= raddr;

		if (state_q == ST_WRITE && match_found_q) outcome_q <= OUTCOME_REPLACED;
		if (state_q == ST_EVICT) evicted_q <= evicted_q + CW'(1);

		if (load_result) begin
			r_hit_q       <= hit_q;
			r_fh_q        <= fh_q;
			r_fb_q        <= fb_q;
			r_outcome_q   <= outcome_q;
			r_evicted_q   <= OUT_CW'(evicted_q);
			r_discarded_q <= OUT_CW'(discarded_q);
			r_empty_q     <= empty_q;
			r_first_q     <= first_q;
			r_last_q      <= last_q;
			r_used_q      <= used_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign hit             = r_hit_q;
	assign found_handle    = r_fh_q;
	assign found_bytes     = r_fb_q;
	assign insert_outcome  = r_outcome_q;
	assign evicted_count   = r_evicted_q;
	assign discarded_count = r_discarded_q;
	assign is_empty        = r_empty_q;
	assign first_index     = r_first_q;
	assign last_index      = r_last_q;
	assign used_bytes      = r_used_q;

	`BBFC_ASSERT_NEXT(a_accept_decodes, in_valid && !in_stall, state_q == ST_DECODE, "Accepted transaction did not reach decode.")
	`BBFC_ASSERT_SAME(a_count_matches, 1'b1, count_q == CW'($countones(valid_q)), "Entry count differs from valid bits.")
	`BBFC_ASSERT_SAME(a_empty_no_bytes, out_valid && is_empty, used_bytes == '0, "Empty table reports bytes in use.")
	`BBFC_ASSERT_SAME(a_write_has_slot, ram_we, match_found_q || free_found_q, "Entry write without a target slot.")

endmodule

>>> sim/byte_budget_frame_cache_unit_test.sv
// Self-checking testbench of the byte budget frame cache: a directed table, then random traffic.
// Depends on bbfc_pkg and byte_budget_frame_cache_unit; results checked by model or typed row.
module byte_budget_frame_cache_unit_test;
	import bbfc_pkg::*;

	typedef struct {
		logic [2:0]  op;
		logic [31:0] idx;
		logic [31:0] bytes;
		logic        fvalid;
		logic [15:0] handle;
		logic [31:0] gen;
	} request_t;

	typedef struct {
		logic        hit;
		logic [15:0] handle;
		logic [31:0] bytes;
		logic [1:0]  outcome;
		logic [6:0]  evicted;
		logic [6:0]  discarded;
		logic        empty;
		logic [31:0] first;
		logic [31:0] last;
		logic [47:0] used;
	} summary_t;

	typedef struct {
		request_t req;
		bit       typed;
		summary_t res;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_write = 0;
	logic [39:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic [2:0] operation = '0;
	logic [31:0] frame_index = '0;
	logic [31:0] frame_bytes = '0;
	logic frame_valid = 0;
	logic [15:0] frame_handle = '0;
	logic [31:0] generation = '0;
	logic out_valid;
	logic out_stall = 0;
	logic hit;
	logic [15:0] found_handle;
	logic [31:0] found_bytes;
	logic [1:0] insert_outcome;
	logic [6:0] evicted_count;
	logic [6:0] discarded_count;
	logic is_empty;
	logic [31:0] first_index;
	logic [31:0] last_index;
	logic [47:0] used_bytes;

	byte_budget_frame_cache_unit dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Shadow copy of the table.
	bit          tbl_valid[SLOTS];
	logic [31:0] tbl_index[SLOTS];
	logic [31:0] tbl_bytes[SLOTS];
	logic [15:0] tbl_handle[SLOTS];
	logic [47:0] tbl_used;
	logic [31:0] tbl_gen;
	logic [39:0] budget;

	summary_t expected_results[$];
	bit       typed_q[$];
	summary_t typed_res_q[$];
	int errors = 0;
	int results_seen = 0;
	int inserts_seen = 0;
	int evictions_seen = 0;
	bit idle_free = 0;
	bit hold_off = 0;
	longint cycles = 0;

	function automatic int find_slot(logic [31:0] idx);
		for (int i = 0; i < SLOTS; i++)
			if (tbl_valid[i] && tbl_index[i] == idx)
				return i;
		return -1;
	endfunction

	function automatic int entry_count();
		int n = 0;
		for (int i = 0; i < SLOTS; i++)
			n += tbl_valid[i];
		return n;
	endfunction

	function automatic int wipe_table();
		int n = entry_count();
		foreach (tbl_valid[i])
			tbl_valid[i] = 0;
		tbl_used = '0;
		return n;
	endfunction

	function automatic summary_t predict_frame_cache(request_t r);
		summary_t s = '{default: '0};
		int k;
		int hi;
		s.empty = 1;
		case (r.op)
			OP_INSERT: begin
				k = find_slot(r.idx);
				if (!r.fvalid || r.gen != tbl_gen) begin
					s.outcome = OUTCOME_REJECTED;
				end else if (k >= 0) begin
					tbl_used = tbl_used - tbl_bytes[k] + r.bytes;
					tbl_bytes[k] = r.bytes;
					tbl_handle[k] = r.handle;
					s.outcome = OUTCOME_REPLACED;
				end else begin
					for (k = 0; k < SLOTS && tbl_valid[k]; k++) ;
					if (k < SLOTS) begin
						tbl_valid[k] = 1;
						tbl_index[k] = r.idx;
						tbl_bytes[k] = r.bytes;
						tbl_handle[k] = r.handle;
						tbl_used = tbl_used + r.bytes;
					end
					while (entry_count() > 1 && (tbl_used > budget || entry_count() > CAPACITY)) begin
						hi = -1;
						for (int i = 0; i < SLOTS; i++)
							if (tbl_valid[i] && (hi < 0 || tbl_index[i] > tbl_index[hi]))
								hi = i;
						tbl_used = tbl_used - tbl_bytes[hi];
						tbl_valid[hi] = 0;
						s.evicted++;
					end
				end
			end
			OP_FIND: begin
				k = find_slot(r.idx);
				if (k >= 0) begin
					s.hit = 1;
					s.handle = tbl_handle[k];
					s.bytes = tbl_bytes[k];
				end
			end
			OP_DISCARD: begin
				for (int i = 0; i < SLOTS; i++)
					if (tbl_valid[i] && tbl_index[i] < r.idx) begin
						tbl_used = tbl_used - tbl_bytes[i];
						tbl_valid[i] = 0;
						s.discarded++;
					end
			end
			OP_CLEAR: s.discarded = wipe_table();
			OP_SET_GEN: begin
				if (r.gen != tbl_gen) begin
					s.discarded = wipe_table();
					tbl_gen = r.gen;
				end
			end
			default: ;
		endcase
		for (int i = 0; i < SLOTS; i++)
			if (tbl_valid[i]) begin
				if (s.empty || tbl_index[i] < s.first)
					s.first = tbl_index[i];
				if (s.empty || tbl_index[i] > s.last)
					s.last = tbl_index[i];
				s.empty = 0;
			end
		s.used = tbl_used;
		return s;
	endfunction

	function automatic request_t random_request(int mode);
		request_t r;
		int pick = $urandom_range(99);
		r.idx = (mode == 0) ? 32'($urandom_range(40)) : $urandom;
		r.bytes = (mode == 0) ? 32'($urandom_range(200)) : $urandom;
		r.fvalid = ($urandom_range(9) != 0);
		r.handle = 16'($urandom);
		r.gen = ($urandom_range(9) == 0) ? $urandom : tbl_gen;
		if (pick < 55) r.op = OP_INSERT;
		else if (pick < 80) r.op = OP_FIND;
		else if (pick < 88) r.op = OP_DISCARD;
		else if (pick < 92) r.op = OP_CLEAR;
		else if (pick < 97) r.op = OP_SET_GEN;
		else r.op = 3'($urandom_range(7, 5));
		if (r.op == OP_SET_GEN && $urandom_range(1))
			r.gen = $urandom_range(3);
		return r;
	endfunction

	// A typed row carries its own expected result, which replaces the prediction.
	task automatic send_row(row_t row);
		typed_q.push_back(row.typed);
		if (row.typed)
			typed_res_q.push_back(row.res);
		while (!idle_free && $urandom_range(99) < 21) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		operation <= row.req.op;
		frame_index <= row.req.idx;
		frame_bytes <= row.req.bytes;
		frame_valid <= row.req.fvalid;
		frame_handle <= row.req.handle;
		generation <= row.req.gen;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (row.req.op == OP_INSERT) inserts_seen++;
	endtask

	task automatic send_request(request_t r);
		row_t row;
		row.req = r;
		row.typed = 0;
		row.res = '{default: '0};
		send_row(row);
	endtask

	task automatic drain_queue();
		in_valid <= 0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_budget(logic [39:0] value);
		cfg_write <= 1;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 0;
		budget = value;
	endtask

	// The prediction is made as the transaction is accepted.
	always @(posedge clk)
		if (arst_n && in_valid && !in_stall)
			expected_results.push_back(predict_frame_cache('{operation, frame_index,
				frame_bytes, frame_valid, frame_handle, generation}));

	always @(posedge clk) begin
		summary_t e;
		bit typed;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				e = expected_results.pop_front();
				typed = 0;
				if (typed_q.size() != 0)
					typed = typed_q.pop_front();
				if (typed)
					e = typed_res_q.pop_front();
				evictions_seen += evicted_count;
				if (hit !== e.hit) begin $error("hit exp %0h got %0h", e.hit, hit); errors++; end
				if (found_handle !== e.handle) begin
					$error("found_handle exp %0h got %0h", e.handle, found_handle); errors++;
				end
				if (found_bytes !== e.bytes) begin
					$error("found_bytes exp %0h got %0h", e.bytes, found_bytes); errors++;
				end
				if (insert_outcome !== e.outcome) begin
					$error("insert_outcome exp %0h got %0h", e.outcome, insert_outcome); errors++;
				end
				if (evicted_count !== e.evicted) begin
					$error("evicted_count exp %0d got %0d", e.evicted, evicted_count); errors++;
				end
				if (discarded_count !== e.discarded) begin
					$error("discarded_count exp %0d got %0d", e.discarded, discarded_count);
					errors++;
				end
				if (is_empty !== e.empty) begin
					$error("is_empty exp %0h got %0h", e.empty, is_empty); errors++;
				end
				if (first_index !== e.first) begin
					$error("first_index exp %0h got %0h", e.first, first_index); errors++;
				end
				if (last_index !== e.last) begin
					$error("last_index exp %0h got %0h", e.last, last_index); errors++;
				end
				if (used_bytes !== e.used) begin
					$error("used_bytes exp %0h got %0h", e.used, used_bytes); errors++;
				end
			end
		end
	end

	// Receiver: random stalls, none while idle_free is set, a long hold when hold_off is set.
	always @(posedge clk) begin
		if (hold_off)
			out_stall <= 1;
		else
			out_stall <= !idle_free && ($urandom_range(99) < 21);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 3000000) begin
			$display("tb: failure");
			$finish;
		end
	end

	row_t directed[$];

	initial begin
		request_t r;
		summary_t blank;
		blank = '{default: '0};
		blank.empty = 1;
		foreach (tbl_valid[i])
			tbl_valid[i] = 0;
		tbl_used = '0;
		tbl_gen = '0;
		budget = 40'd536870912;

		directed.push_back('{'{OP_FIND, 32'd5, 0, 1, 0, 0}, 1, blank});
		directed.push_back('{'{OP_CLEAR, 0, 0, 0, 0, 0}, 1, blank});
		directed.push_back('{'{3'd7, 32'hFFFF_FFFF, 0, 1, 16'hFFFF, 0}, 1, blank});
		directed.push_back('{'{3'd5, 0, 0, 0, 0, 0}, 0, blank});
		directed.push_back('{'{3'd6, 0, 0, 0, 0, 0}, 0, blank});
		blank.outcome = OUTCOME_REJECTED;
		directed.push_back('{'{OP_INSERT, 32'd3, 32'd10, 0, 16'h1, 0}, 1, blank});
		directed.push_back('{'{OP_INSERT, 32'd3, 32'd10, 1, 16'h1, 32'd9}, 1, blank});
		blank.outcome = OUTCOME_ADDED;
		directed.push_back('{'{OP_INSERT, 32'hFFFF_FFFF, 32'd100, 1, 16'hFFFF, 0}, 0, blank});
		directed.push_back('{'{OP_INSERT, 32'd0, 32'd0, 1, 16'h0, 0}, 0, blank});
		directed.push_back('{'{OP_INSERT, 32'd7, 32'd50, 1, 16'hAAAA, 0}, 0, blank});
		directed.push_back('{'{OP_INSERT, 32'd7, 32'd60, 1, 16'h5555, 0}, 0, blank});
		directed.push_back('{'{OP_FIND, 32'd7, 0, 0, 0, 0}, 0, blank});
		directed.push_back('{'{OP_FIND, 32'hFFFF_FFFF, 0, 0, 0, 0}, 0, blank});
		directed.push_back('{'{OP_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, 1, 16'h1234, 0}, 0, blank});
		directed.push_back('{'{OP_INSERT, 32'd9, 32'd1 << 29, 1, 16'h4321, 0}, 0, blank});
		directed.push_back('{'{OP_DISCARD, 32'd7, 0, 0, 0, 0}, 0, blank});
		directed.push_back('{'{OP_DISCARD, 32'd0, 0, 0, 0, 0}, 0, blank});
		directed.push_back('{'{OP_SET_GEN, 0, 0, 0, 0, 32'd0}, 0, blank});
		directed.push_back('{'{OP_SET_GEN, 0, 0, 0, 0, 32'hFFFF_FFFF}, 0, blank});
		directed.push_back('{'{OP_INSERT, 32'd4, 32'd8, 1, 16'h9, 32'hFFFF_FFFF}, 0, blank});
		directed.push_back('{'{OP_CLEAR, 0, 0, 0, 0, 0}, 0, blank});
		directed.push_back('{'{OP_SET_GEN, 0, 0, 0, 0, 32'd0}, 0, blank});

		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (directed[i])
			send_row(directed[i]);
		drain_queue();

		// Small budget: eviction of fresh entries, including the new one itself.
		write_budget(40'd300);
		for (int i = 0; i < 100; i++)
			send_request(random_request(0));
		drain_queue();

		// Budget zero: an insert evicts until one entry is left or none holds bytes.
		write_budget(40'd0);
		for (int i = 0; i < 30; i++)
			send_request(random_request(0));
		drain_queue();

		// Budget maximum: capacity bound and full-width sizes; a long receiver hold.
		write_budget(40'hFF_FFFF_FFFF);
		hold_off = 1;
		fork
			for (int i = 0; i < 140; i++) begin
				r = random_request(1);
				if (i < 90) begin r.op = OP_INSERT; r.fvalid = 1; r.gen = tbl_gen; end
				send_request(r);
			end
			begin
				repeat (2000) @(posedge clk);
				hold_off = 0;
			end
		join
		drain_queue();

		write_budget(40'd536870912);
		idle_free = 1;
		for (int i = 0; i < 60; i++)
			send_request(random_request($urandom_range(1)));
		idle_free = 0;
		for (int i = 0; i < 80; i++)
			send_request(random_request($urandom_range(1)));
		drain_queue();

		$display("Covered %0d results, %0d inserts, %0d evictions over four budget settings.",
			results_seen, inserts_seen, evictions_seen);
		if (errors == 0 && expected_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

>>> sim.f
+incdir+design
design/bbfc_pkg.sv
design/bbfc_ram.sv
design/byte_budget_frame_cache_unit.sv
sim/byte_budget_frame_cache_unit_test.sv
